### rtl/drg_pkg.sv
`default_nettype none

package drg_pkg;

    localparam int MAX_DIM    = 1024;

    localparam int IDX_W      = 10;
    localparam int COEF_W     = 32;

    localparam int D_W        = 21;
    localparam int R_PAD      = 16;
    localparam int RAD_W      = 38;
    localparam int ROOT_W     = 19;
    localparam int REM_W      = 21;
    localparam int SQ_STEPS   = 19;
    localparam int SQ_STAGES  = SQ_STEPS + 1;

    localparam int T_W        = 34;
    localparam int T_FRAC     = 24;
    localparam int HI_W       = 4;
    localparam int G_W        = 20;
    localparam int N_W        = T_W - T_FRAC;
    localparam int SH_W       = 5;
    localparam int EXP_N_MAX  = 17;
    localparam int EXP_RND_SH = 13;

    localparam int UG_W       = 50;
    localparam int U_W        = 26;
    localparam int UU_W       = 2 * U_W;
    localparam int FRAC30     = 30;
    localparam int UH_W       = UU_W - FRAC30;
    localparam int W3_W       = UH_W + U_W;
    localparam int W_W        = W3_W - FRAC30;
    localparam int PP_W       = 31;
    localparam int RECIP_SH   = 21;
    localparam int C_W        = 37;
    localparam int CUBE_W     = C_W - RECIP_SH;
    localparam int TAB_W      = 31;
    localparam int MP_W       = TAB_W + PP_W;
    localparam int M_W        = 31;
    localparam int E_W        = 17;
    localparam int GAIN_W     = 17;
    localparam int EXP_STAGES = 7;

    localparam int PROD_W     = COEF_W + GAIN_W;
    localparam int ROUND_SH   = 16;
    localparam int Q_W        = PROD_W - ROUND_SH;
    localparam int SCL_STAGES = 2;

    localparam int TOTAL_STAGES = SQ_STAGES + EXP_STAGES + SCL_STAGES;

    localparam logic [T_W-1:0]    EXP_K_Q16       = T_W'(18910);
    localparam logic [UG_W-1:0]   LN2_Q30         = UG_W'(744261118);
    localparam logic [PP_W-1:0]   ONE_Q30         = PP_W'(1073741824);
    localparam logic [C_W-1:0]    RECIP6          = C_W'(349526);
    localparam logic [E_W-1:0]    E16_MAX         = E_W'(65536);
    localparam logic [GAIN_W-1:0] GAIN_OFFSET_Q16 = GAIN_W'(98304);
    localparam logic [PROD_W-1:0] ROUND_HALF      = PROD_W'(32768);
    localparam logic [Q_W-1:0]    POS_LIMIT       = Q_W'(33'h0_7FFF_FFFF);
    localparam logic [Q_W-1:0]    NEG_LIMIT       = Q_W'(33'h0_8000_0000);

    typedef struct packed {
        logic        [IDX_W-1:0]  column_index;
        logic        [IDX_W-1:0]  row_index;
        logic signed [COEF_W-1:0] coefficient;
    } t_in_word;

    typedef struct packed {
        logic signed [COEF_W-1:0] scaled_coefficient;
        logic                     saturated;
    } t_out_word;

    function automatic logic [IDX_W-1:0] clamp_index(input logic [IDX_W-1:0] v);
        logic [IDX_W-1:0] r;
        r = v;
        if (32'(v) >= MAX_DIM) begin
            r = IDX_W'(MAX_DIM - 1);
        end
        return r;
    endfunction

    function automatic logic [TAB_W-1:0] pow2_frac(input logic [HI_W-1:0] i);
        logic [TAB_W-1:0] r;
        case (i)
            4'd0:    r = TAB_W'(1073741824);
            4'd1:    r = TAB_W'(1028218693);
            4'd2:    r = TAB_W'(984625594);
            4'd3:    r = TAB_W'(942880699);
            4'd4:    r = TAB_W'(902905651);
            4'd5:    r = TAB_W'(864625413);
            4'd6:    r = TAB_W'(827968132);
            4'd7:    r = TAB_W'(792865000);
            4'd8:    r = TAB_W'(759250125);
            4'd9:    r = TAB_W'(727060410);
            4'd10:   r = TAB_W'(696235434);
            4'd11:   r = TAB_W'(666717336);
            4'd12:   r = TAB_W'(638450708);
            4'd13:   r = TAB_W'(611382493);
            4'd14:   r = TAB_W'(585461881);
            4'd15:   r = TAB_W'(560640218);
            default: r = TAB_W'(1073741824);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/drg_sqrt.sv
`default_nettype none

module drg_sqrt (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  drg_pkg::t_in_word                   i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic        [drg_pkg::ROOT_W-1:0]   o_root,
    output logic signed [drg_pkg::COEF_W-1:0]   o_coef
);
    import drg_pkg::*;

    localparam int N = SQ_STAGES;

    logic [N-1:0]             r_vld;
    logic [N-1:0]             n_vld;
    logic [N-1:0]             w_en;
    logic [RAD_W-1:0]         r_rad  [N];
    logic [ROOT_W-1:0]        r_root [N];
    logic [REM_W-1:0]         r_rem  [N];
    logic signed [COEF_W-1:0] r_coef [N];

    logic [IDX_W-1:0]   w_x;
    logic [IDX_W-1:0]   w_y;
    logic [2*IDX_W-1:0] w_xx;
    logic [2*IDX_W-1:0] w_yy;
    logic [D_W-1:0]     w_d;

    assign w_en    = ~r_vld | {i_ready, w_en[N-1:1]};
    assign o_ready = w_en[0];
    assign n_vld   = (w_en & {r_vld[N-2:0], i_valid}) | (~w_en & r_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_x  = clamp_index(i_data.column_index);
    assign w_y  = clamp_index(i_data.row_index);
    assign w_xx = w_x * w_x;
    assign w_yy = w_y * w_y;
    assign w_d  = D_W'(w_xx) + D_W'(w_yy);

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_rad[0]  <= RAD_W'(w_d) << R_PAD;
            r_root[0] <= '0;
            r_rem[0]  <= '0;
            r_coef[0] <= i_data.coefficient;
        end
    end

    for (genvar k = 1; k < N; k++) begin : g_step
        logic [REM_W+1:0] w_sh;
        logic [REM_W+1:0] w_trial;
        logic             w_ge;

        assign w_sh    = {r_rem[k-1], r_rad[k-1][RAD_W-1 -: 2]};
        assign w_trial = (REM_W+2)'({r_root[k-1], 2'b01});
        assign w_ge    = (w_sh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_rad[k]  <= r_rad[k-1] << 2;
                r_root[k] <= {r_root[k-1][ROOT_W-2:0], w_ge};
                r_rem[k]  <= w_ge ? REM_W'(w_sh - w_trial) : REM_W'(w_sh);
                r_coef[k] <= r_coef[k-1];
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_root[N-1];
    assign o_coef  = r_coef[N-1];

endmodule

`default_nettype wire

### rtl/drg_exp.sv
`default_nettype none

module drg_exp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic        [drg_pkg::ROOT_W-1:0]   i_root,
    input  logic signed [drg_pkg::COEF_W-1:0]   i_coef,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic        [drg_pkg::GAIN_W-1:0]   o_gain,
    output logic signed [drg_pkg::COEF_W-1:0]   o_coef
);
    import drg_pkg::*;

    localparam int N = EXP_STAGES;

    logic [N-1:0]             r_vld;
    logic [N-1:0]             n_vld;
    logic [N-1:0]             w_en;
    logic signed [COEF_W-1:0] r_coef [N];
    logic [HI_W-1:0]          r_hi   [N];
    logic [SH_W-1:0]          r_sh   [N];
    logic [N-1:0]             r_zero;

    logic [G_W-1:0]    r_g;
    logic [U_W-1:0]    r1_u;
    logic [U_W-1:0]    r2_u;
    logic [UU_W-1:0]   r2_uu;
    logic [W_W-1:0]    r3_w;
    logic [PP_W-1:0]   r3_pp;
    logic [PP_W-1:0]   r4_p;
    logic [M_W-1:0]    r5_m;
    logic [GAIN_W-1:0] r6_gain;

    logic [T_W-1:0]    w_t;
    logic [N_W-1:0]    w_n;
    logic [UG_W-1:0]   w_ug;
    logic [W3_W-1:0]   w_w;
    logic [C_W-1:0]    w_c;
    logic [MP_W-1:0]   w_m;
    logic [M_W-1:0]    w_ms;
    logic [E_W:0]      w_rnd;
    logic [E_W-1:0]    w_e;

    assign w_en    = ~r_vld | {i_ready, w_en[N-1:1]};
    assign o_ready = w_en[0];
    assign n_vld   = (w_en & {r_vld[N-2:0], i_valid}) | (~w_en & r_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_t  = T_W'(i_root) * EXP_K_Q16;
    assign w_n  = w_t[T_W-1:T_FRAC];
    assign w_ug = UG_W'(r_g) * LN2_Q30;
    assign w_w  = W3_W'(r2_uu[UU_W-1:FRAC30]) * W3_W'(r2_u);
    assign w_c  = C_W'(r3_w) * RECIP6;
    assign w_m  = MP_W'(pow2_frac(r_hi[4])) * MP_W'(r4_p);

    assign w_ms  = r5_m >> r_sh[5];
    assign w_rnd = (E_W+1)'(w_ms) + (E_W+1)'(1);

    always_comb begin
        w_e = E_W'(w_rnd >> 1);
        if (r_zero[5]) begin
            w_e = '0;
        end else if (w_e > E16_MAX) begin
            w_e = E16_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_coef[0] <= i_coef;
            r_hi[0]   <= w_t[T_FRAC-1 -: HI_W];
            r_sh[0]   <= SH_W'(EXP_RND_SH) + SH_W'(w_n);
            r_zero[0] <= (w_n > N_W'(EXP_N_MAX));
            r_g       <= w_t[G_W-1:0];
        end
        for (int k = 1; k < N; k++) begin
            if (w_en[k]) begin
                r_coef[k] <= r_coef[k-1];
                r_hi[k]   <= r_hi[k-1];
                r_sh[k]   <= r_sh[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
        if (w_en[1]) begin
            r1_u <= w_ug[UG_W-1 -: U_W];
        end
        if (w_en[2]) begin
            r2_u  <= r1_u;
            r2_uu <= UU_W'(r1_u) * UU_W'(r1_u);
        end
        if (w_en[3]) begin
            r3_w  <= w_w[W3_W-1:FRAC30];
            r3_pp <= ONE_Q30 - PP_W'(r2_u) + PP_W'(r2_uu[UU_W-1:FRAC30+1]);
        end
        if (w_en[4]) begin
            r4_p <= r3_pp - PP_W'(w_c[C_W-1:RECIP_SH]);
        end
        if (w_en[5]) begin
            r5_m <= w_m[FRAC30 +: M_W];
        end
        if (w_en[6]) begin
            r6_gain <= GAIN_OFFSET_Q16 - GAIN_W'(w_e);
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_gain  = r6_gain;
    assign o_coef  = r_coef[N-1];

endmodule

`default_nettype wire

### rtl/drg_scale.sv
`default_nettype none

module drg_scale (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic        [drg_pkg::GAIN_W-1:0]   i_gain,
    input  logic signed [drg_pkg::COEF_W-1:0]   i_coef,
    output logic                                o_valid,
    input  logic                                i_ready,
    output drg_pkg::t_out_word                  o_data
);
    import drg_pkg::*;

    localparam int N = SCL_STAGES;

    logic [N-1:0]      r_vld;
    logic [N-1:0]      n_vld;
    logic [N-1:0]      w_en;
    logic [PROD_W-1:0] r_prod;
    logic              r_neg;
    t_out_word         r_out;

    logic              w_neg;
    logic [COEF_W-1:0] w_mag;
    logic [PROD_W-1:0] w_sum;
    logic [Q_W-1:0]    w_q;
    logic [Q_W-1:0]    w_qc;
    logic              w_sat;

    assign w_en    = ~r_vld | {i_ready, w_en[N-1:1]};
    assign o_ready = w_en[0];
    assign n_vld   = (w_en & {r_vld[N-2:0], i_valid}) | (~w_en & r_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_neg = i_coef[COEF_W-1];
    assign w_mag = w_neg ? (~COEF_W'(i_coef) + COEF_W'(1)) : COEF_W'(i_coef);

    assign w_sum = r_prod + ROUND_HALF;
    assign w_q   = w_sum[PROD_W-1:ROUND_SH];

    always_comb begin
        w_qc  = w_q;
        w_sat = 1'b0;
        if (!r_neg && (w_q > POS_LIMIT)) begin
            w_qc  = POS_LIMIT;
            w_sat = 1'b1;
        end else if (r_neg && (w_q > NEG_LIMIT)) begin
            w_qc  = NEG_LIMIT;
            w_sat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_neg  <= w_neg;
            r_prod <= PROD_W'(w_mag) * PROD_W'(i_gain);
        end
        if (w_en[1]) begin
            r_out.scaled_coefficient <= r_neg ? (~w_qc[COEF_W-1:0] + COEF_W'(1))
                                              : w_qc[COEF_W-1:0];
            r_out.saturated          <= w_sat;
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_data  = r_out;

endmodule

`default_nettype wire

### rtl/dct_radial_emphasis_gain_top.sv
// Throughput: one word per cycle while the output is not stalled; the square-root ladder sets most of the depth.
// Stalls hold each stage; empty stages keep accepting until the pipe is full.
// Reset: synchronous, active low on i_rst_n; clears all valid bits, payload is not reset.
`default_nettype none

module dct_radial_emphasis_gain_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  drg_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output drg_pkg::t_out_word o_data
);
    import drg_pkg::*;

    localparam int CNT_W = $clog2(TOTAL_STAGES + 1);

    logic                     w_sq_valid;
    logic                     w_sq_ready;
    logic [ROOT_W-1:0]        w_sq_root;
    logic signed [COEF_W-1:0] w_sq_coef;

    logic                     w_ex_valid;
    logic                     w_ex_ready;
    logic [GAIN_W-1:0]        w_ex_gain;
    logic signed [COEF_W-1:0] w_ex_coef;

    logic [CNT_W-1:0]         r_inflight;
    logic [CNT_W-1:0]         n_inflight;

    drg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (w_sq_valid),
        .i_ready (w_sq_ready),
        .o_root  (w_sq_root),
        .o_coef  (w_sq_coef)
    );

    drg_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .o_ready (w_sq_ready),
        .i_root  (w_sq_root),
        .i_coef  (w_sq_coef),
        .o_valid (w_ex_valid),
        .i_ready (w_ex_ready),
        .o_gain  (w_ex_gain),
        .o_coef  (w_ex_coef)
    );

    drg_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ex_valid),
        .o_ready (w_ex_ready),
        .i_gain  (w_ex_gain),
        .i_coef  (w_ex_coef),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    assign n_inflight = r_inflight + CNT_W'(i_valid && o_ready) - CNT_W'(o_valid && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    a_empty_pipe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == '0) |-> (!o_valid && o_ready))
        else $error("empty pipe shows a result or refuses a word");

    a_occupancy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight <= CNT_W'(TOTAL_STAGES)))
        else $error("more words in flight than stages");

    a_gain_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ex_valid |-> ((w_ex_gain >= GAIN_W'(32768)) && (w_ex_gain <= GAIN_OFFSET_Q16)))
        else $error("gain out of range");

    a_sat_value : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.saturated) |->
        ((o_data.scaled_coefficient == 32'sh7FFF_FFFF) ||
         (o_data.scaled_coefficient == 32'sh8000_0000)))
        else $error("saturated word not at a rail");

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import drg_pkg::*;

    localparam logic [63:0] EXP2_FRAC [16] = '{
        64'd1073741824, 64'd1028218693, 64'd984625594, 64'd942880699,
        64'd902905651,  64'd864625413,  64'd827968132, 64'd792865000,
        64'd759250125,  64'd727060410,  64'd696235434, 64'd666717336,
        64'd638450708,  64'd611382493,  64'd585461881, 64'd560640218
    };

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_ready = 1'b0;
    t_in_word  i_data  = '0;
    logic      o_ready;
    logic      o_valid;
    t_out_word o_data;

    t_in_word  pending_words [$];
    t_out_word expected_scaled [$];
    t_out_word want;
    int        failures       = 0;
    int        words_accepted = 0;
    int        burst_left     = 0;
    int        gap_left       = 0;
    int        hold_left      = 0;
    logic      hold_done      = 1'b0;
    logic [7:0] stall_phase   = '0;

    dct_radial_emphasis_gain_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] probe;
        rem   = v;
        res   = '0;
        probe = 64'd1 << 62;
        while (probe > rem) begin
            probe = probe >> 2;
        end
        while (probe != 0) begin
            if (rem >= res + probe) begin
                rem = rem - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] emphasis_gain(input logic [IDX_W-1:0] col,
                                                  input logic [IDX_W-1:0] row);
        logic [63:0] x, y, r8, t, n, hi, g, u, uu, cube, p, m, e16;
        x = 64'(col);
        y = 64'(row);
        if (x >= MAX_DIM) begin
            x = MAX_DIM - 1;
        end
        if (y >= MAX_DIM) begin
            y = MAX_DIM - 1;
        end
        r8   = floor_root((x * x + y * y) << 16);
        t    = r8 * 64'd18910;
        n    = t >> 24;
        hi   = (t >> 20) & 64'd15;
        g    = t & 64'hF_FFFF;
        u    = (g * 64'd744261118) >> 24;
        uu   = u * u;
        cube = (((uu >> 30) * u) >> 30) / 64'd6;
        p    = 64'd1073741824 - u + (uu >> 31) - cube;
        m    = (EXP2_FRAC[hi[3:0]] * p) >> 30;
        e16  = '0;
        if (n < 32) begin
            e16 = (m + (64'd1 << (13 + n))) >> (14 + n);
        end
        if (e16 > 64'd65536) begin
            e16 = 64'd65536;
        end
        return 64'd98304 - e16;
    endfunction

    function automatic t_out_word scale_coefficient(input t_in_word w);
        logic [31:0] c;
        logic [63:0] mag, q;
        logic        neg;
        t_out_word   r;
        c   = w.coefficient;
        neg = c[31];
        mag = neg ? 64'h1_0000_0000 - {32'd0, c} : {32'd0, c};
        q   = (mag * emphasis_gain(w.column_index, w.row_index) + 64'd32768) >> 16;
        r.saturated = 1'b0;
        if (!neg) begin
            if (q > 64'h7FFF_FFFF) begin
                q = 64'h7FFF_FFFF;
                r.saturated = 1'b1;
            end
            r.scaled_coefficient = q[31:0];
        end else begin
            if (q > 64'h8000_0000) begin
                q = 64'h8000_0000;
                r.saturated = 1'b1;
            end
            r.scaled_coefficient = 32'(64'h1_0000_0000 - q);
        end
        return r;
    endfunction

    function automatic t_in_word make_word(input int col, input int row, input logic [31:0] c);
        t_in_word w;
        w.column_index = IDX_W'(col);
        w.row_index    = IDX_W'(row);
        w.coefficient  = c;
        return w;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (pending_words.size() != 0) begin
                i_data  <= pending_words.pop_front();
                i_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            stall_phase <= stall_phase + 8'd1;
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_ready   <= 1'b0;
            end else if (!hold_done && words_accepted >= 150) begin
                hold_done <= 1'b1;
                hold_left <= 200;
                i_ready   <= 1'b0;
            end else begin
                case (stall_phase[7:6])
                    2'd0: begin
                        i_ready <= 1'b1;
                    end
                    2'd1: begin
                        i_ready <= ($urandom_range(0, 3) != 0);
                    end
                    2'd2: begin
                        i_ready <= (stall_phase[1:0] != 2'd3);
                    end
                    default: begin
                        i_ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_scaled.push_back(scale_coefficient(i_data));
                words_accepted <= words_accepted + 1;
            end
            if (o_valid && i_ready) begin
                if (expected_scaled.size() == 0) begin
                    failures = failures + 1;
                    if (failures <= 10) begin
                        $display("unexpected word: scaled %0d sat %0b",
                                 o_data.scaled_coefficient, o_data.saturated);
                    end
                end else begin
                    want = expected_scaled.pop_front();
                    if (o_data.scaled_coefficient !== want.scaled_coefficient ||
                        o_data.saturated !== want.saturated) begin
                        failures = failures + 1;
                        if (failures <= 10) begin
                            $display("mismatch: expected scaled %0d sat %0b, got scaled %0d sat %0b",
                                     want.scaled_coefficient, want.saturated,
                                     o_data.scaled_coefficient, o_data.saturated);
                        end
                    end
                end
            end
        end
    end

    initial begin
        int          sel;
        logic [31:0] c;
        pending_words.push_back(make_word(0, 0, 32'd0));
        pending_words.push_back(make_word(0, 0, 32'd1));
        pending_words.push_back(make_word(0, 0, 32'hFFFF_FFFF));
        pending_words.push_back(make_word(0, 0, 32'd3));
        pending_words.push_back(make_word(0, 0, 32'hFFFF_FFFD));
        pending_words.push_back(make_word(0, 0, 32'h7FFF_FFFF));
        pending_words.push_back(make_word(0, 0, 32'h8000_0000));
        pending_words.push_back(make_word(1023, 1023, 32'h7FFF_FFFF));
        pending_words.push_back(make_word(1023, 1023, 32'h8000_0000));
        pending_words.push_back(make_word(1023, 1023, 32'h5555_5555));
        pending_words.push_back(make_word(1023, 1023, 32'hAAAA_AAAA));
        pending_words.push_back(make_word(1023, 0, 32'h0001_0000));
        pending_words.push_back(make_word(0, 1023, 32'hFFFF_0000));
        pending_words.push_back(make_word(1, 0, 32'h0001_0000));
        pending_words.push_back(make_word(0, 1, 32'h0001_0000));
        pending_words.push_back(make_word(3, 4, 32'h0001_0000));
        pending_words.push_back(make_word(5, 0, 32'hFFFF_0000));
        pending_words.push_back(make_word(7, 9, 32'h4000_0000));
        pending_words.push_back(make_word(7, 9, 32'hC000_0000));
        pending_words.push_back(make_word(30, 40, 32'h5555_5556));
        pending_words.push_back(make_word(1023, 1023, 32'h0000_8000));
        pending_words.push_back(make_word(512, 256, 32'h8000_0001));
        repeat (500) begin
            sel = $urandom_range(0, 9);
            c   = $urandom;
            if (sel < 4) begin
                pending_words.push_back(make_word($urandom_range(0, 15),
                                                  $urandom_range(0, 15), c));
            end else if (sel < 7) begin
                pending_words.push_back(make_word($urandom_range(0, 1023),
                                                  $urandom_range(0, 1023), c));
            end else if (sel < 9) begin
                c = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
                pending_words.push_back(make_word($urandom_range(0, 1023),
                                                  $urandom_range(0, 63), c));
            end else begin
                c = $urandom_range(0, 1) ? 32'h7FFF_FFFF - 32'($urandom_range(0, 3))
                                         : 32'h8000_0000 + 32'($urandom_range(0, 3));
                pending_words.push_back(make_word($urandom_range(0, 1023),
                                                  $urandom_range(0, 1023), c));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (expected_scaled.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);

        if (failures == 0 && expected_scaled.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

### dct_radial_emphasis_gain_top.f
rtl/drg_pkg.sv
rtl/drg_sqrt.sv
rtl/drg_exp.sv
rtl/drg_scale.sv
rtl/dct_radial_emphasis_gain_top.sv
tb/tb.sv
